>>> hw/rtl/crc32_record_checker_macros.svh
// Assertion helpers, clocked on clk and idle during reset
`ifndef CRC32_RECORD_CHECKER_MACROS_SVH
`define CRC32_RECORD_CHECKER_MACROS_SVH

// same-cycle implication
`define CRC32RC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CRC32RC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/crc32rc_pkg.sv
package crc32rc_pkg;

    localparam int unsigned PAYLOAD_BYTES = 128;
    localparam int unsigned HDR_BYTES     = 12;

    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [31:0] REC_MAGIC   = 32'h5054_4348;
    localparam logic [15:0] REC_VERSION = 16'd1;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

    localparam logic [15:0] HDR_LEN_FIELD = 16'(PAYLOAD_BYTES);
    localparam logic [16:0] FRAME_LEN     = 17'(HDR_BYTES + PAYLOAD_BYTES);
    localparam logic [16:0] RAW_LEN       = 17'(PAYLOAD_BYTES);
    localparam logic [15:0] HDR_END       = 16'(HDR_BYTES);

    typedef enum logic [2:0] {
        STATUS_FRAMED_OK  = 3'd0,
        STATUS_RAW_OK     = 3'd1,
        STATUS_WRONG_LEN  = 3'd2,
        STATUS_BAD_MAGIC  = 3'd3,
        STATUS_BAD_VER    = 3'd4,
        STATUS_BAD_SIZE   = 3'd5,
        STATUS_CRC_ERR    = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        logic        accepted;
        status_t     status;
        logic [31:0] crc;
    } verdict_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/crc32rc_track.sv
module crc32rc_track
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  crc32rc_pkg::item_t    item,
    input  logic                  go,
    output crc32rc_pkg::verdict_t verdict
);

`include "crc32_record_checker_macros.svh"

    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [31:0] magic_reg;
    logic [15:0] version_reg;
    logic [15:0] length_reg;
    logic [31:0] checksum_reg;
    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [31:0] crc_out;
    logic [16:0] len;
    logic        crc_upd;

    assign crc_upd = (count_reg >= crc32rc_pkg::HDR_END)
                     && ({1'b0, count_reg} < crc32rc_pkg::FRAME_LEN)
                     && (count_reg != crc32rc_pkg::COUNT_MAX);
    assign crc_next = crc_upd ? crc32rc_pkg::crc_byte(crc_reg, item.data) : crc_reg;
    assign crc_out  = ~crc_next;
    assign len      = {1'b0, count_reg} + 17'd1;
    assign count_next = (count_reg == crc32rc_pkg::COUNT_MAX) ? count_reg
                                                              : count_reg + 16'd1;

    always_comb
    begin
        verdict.crc = crc_out;
        if (len >= crc32rc_pkg::FRAME_LEN)
        begin
            if (magic_reg != crc32rc_pkg::REC_MAGIC)
                verdict.status = crc32rc_pkg::STATUS_BAD_MAGIC;
            else if (version_reg != crc32rc_pkg::REC_VERSION)
                verdict.status = crc32rc_pkg::STATUS_BAD_VER;
            else if (length_reg != crc32rc_pkg::HDR_LEN_FIELD)
                verdict.status = crc32rc_pkg::STATUS_BAD_SIZE;
            else if (crc_out != checksum_reg)
                verdict.status = crc32rc_pkg::STATUS_CRC_ERR;
            else
                verdict.status = crc32rc_pkg::STATUS_FRAMED_OK;
        end
        else if (len == crc32rc_pkg::RAW_LEN)
        begin
            verdict.status = crc32rc_pkg::STATUS_RAW_OK;
        end
        else
        begin
            verdict.status = crc32rc_pkg::STATUS_WRONG_LEN;
        end
        verdict.accepted = (verdict.status == crc32rc_pkg::STATUS_FRAMED_OK)
                           || (verdict.status == crc32rc_pkg::STATUS_RAW_OK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= crc32rc_pkg::CRC_INIT;
        end
        else if (go)
        begin
            if (item.last)
            begin
                count_reg <= '0;
                crc_reg   <= crc32rc_pkg::CRC_INIT;
            end
            else
            begin
                count_reg <= count_next;
                crc_reg   <= crc_next;
            end
        end
    end

    // capture header bytes, little-endian
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg    <= '0;
            version_reg  <= '0;
            length_reg   <= '0;
            checksum_reg <= '0;
        end
        else if (go)
        begin
            if (count_reg < 16'd4)
                magic_reg[{count_reg[1:0], 3'b000} +: 8] <= item.data;
            else if (count_reg < 16'd6)
                version_reg[{count_reg[0], 3'b000} +: 8] <= item.data;
            else if (count_reg < 16'd8)
                length_reg[{count_reg[0], 3'b000} +: 8] <= item.data;
            else if (count_reg < crc32rc_pkg::HDR_END)
                checksum_reg[{count_reg[1:0], 3'b000} +: 8] <= item.data;
        end
    end

    `CRC32RC_ASSERT_NEXT(a_count_restart, go && item.last, count_reg == 16'd0,
        "byte count not restarted after record end")
    `CRC32RC_ASSERT_NEXT(a_count_step,
        go && !item.last && (count_reg != crc32rc_pkg::COUNT_MAX),
        count_reg == $past(count_reg) + 16'd1, "byte count did not advance")
    `CRC32RC_ASSERT_NOW(a_framed_crc,
        verdict.status == crc32rc_pkg::STATUS_FRAMED_OK, crc_out == checksum_reg,
        "framed verdict without matching CRC")

endmodule

>>> hw/rtl/crc32_record_checker.sv
// A record's last byte passes the input register, then its verdict loads the result register and out_valid.
// Throughput: one byte per cycle unless a last byte stalls; the CRC byte update and the verdict sit between the
// input register and the result register.
// A waiting verdict stalls only a following last byte; other bytes keep flowing.
// Reset (rst_n low, asynchronous) empties both registers and restarts the record.
module crc32_record_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic [2:0]  status,
    output logic [31:0] computed_crc
);

`include "crc32_record_checker_macros.svh"

    logic                  s1_valid_reg;
    crc32rc_pkg::item_t    s1_item_reg;
    logic                  go;
    crc32rc_pkg::verdict_t verdict;
    logic                  out_valid_reg;
    logic                  accepted_reg;
    crc32rc_pkg::status_t  status_reg;
    logic [31:0]           crc_reg;

    assign go = s1_valid_reg && (!s1_item_reg.last || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !go;

    crc32rc_track u_track
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (s1_item_reg),
        .go      (go),
        .verdict (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_item_reg.data <= data_byte;
            s1_item_reg.last <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (go && s1_item_reg.last)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (go && s1_item_reg.last)
        begin
            accepted_reg <= verdict.accepted;
            status_reg   <= verdict.status;
            crc_reg      <= verdict.crc;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = accepted_reg;
    assign status       = status_reg;
    assign computed_crc = crc_reg;

    `CRC32RC_ASSERT_NOW(a_stall_cause, in_stall,
        s1_valid_reg && s1_item_reg.last && out_valid_reg && out_stall,
        "input stalled without a waiting verdict")
    `CRC32RC_ASSERT_NEXT(a_verdict_load, s1_valid_reg && s1_item_reg.last && !in_stall,
        out_valid_reg, "record end passed without a verdict")
    `CRC32RC_ASSERT_NOW(a_accept_code, out_valid_reg,
        accepted_reg == ((status_reg == crc32rc_pkg::STATUS_FRAMED_OK)
                         || (status_reg == crc32rc_pkg::STATUS_RAW_OK)),
        "accepted flag disagrees with status")

endmodule
